>>> rtl/core/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the ternary spin Metropolis update block.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int SITE_W   = 10;
	localparam int NB_COUNT = 6;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TRY  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [1:0] CFG_TEMPERATURE = 2'd0;
	localparam logic [1:0] CFG_COUPLING    = 2'd1;
	localparam logic [1:0] CFG_FIELD       = 2'd2;

	localparam logic        [15:0] TEMPERATURE_RESET = 16'd512;
	localparam logic signed [15:0] COUPLING_RESET    = 16'sd256;
	localparam logic signed [15:0] FIELD_RESET       = 16'sd0;

	typedef struct packed {
		logic       take_in;
		logic       rd_site;
		logic       split;
		logic       count_try;
		logic       wrap;
		logic       rd_nb;
		logic [2:0] nb_sel;
		logic       mul;
		logic       loc;
		logic       judge;
		logic       load_wr;
		logic       load_out;
		logic       clr_step;
	} tsm_cmd_t;

	typedef struct packed {
		logic       site_ok;
		logic       same;
		logic [1:0] kind;
		logic       clr_last;
	} tsm_status_t;

	// code 2'b10 reads as neutral
	function automatic logic signed [1:0] spin_decode(input logic [1:0] code);
		logic signed [1:0] s;
		s = (code == 2'b10) ? 2'sb00 : $signed(code);
		return s;
	endfunction

endpackage

>>> rtl/core/ternary_spin_metropolis_update_top.sv
// ----------------------------------------------------------------------------
// ternary_spin_metropolis_update_top
// Spin-one Metropolis updates on a toroidal triangular lattice of
// ROWS x COLS ternary cells: load, attempt and read, with magnetization
// and saturating attempt/accept counts.
// ----------------------------------------------------------------------------
//  channel | signals                                         | word taken when
//  in      | in_valid in_ready kind site spin_value log_draw | in_valid & in_ready
//  out     | out_valid out_ready accepted site_spin          | out_valid & out_ready
//          | energy_change magnet_sum accept_total           |
//          | attempt_total                                   |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | cfg_valid & cfg_ready
//
//  Attempt: the six neighbor reads go through the single lattice read port,
//  one per cycle.
//  After reset a clear pass writes zero to all ROWS*COLS cells, one a cycle;
//  in_ready is low for those cycles, cfg is always ready.
//  A finished word waits in the output register; the next input word is
//  taken meanwhile and holds only at its result step until out is free.
// ----------------------------------------------------------------------------
module ternary_spin_metropolis_update_top #(
	parameter int COLS = 32,
	parameter int ROWS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [9:0]         site,
	input  logic signed [1:0]  spin_value,
	input  logic [15:0]        log_draw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic signed [1:0]  site_spin,
	output logic signed [19:0] energy_change,
	output logic signed [11:0] magnet_sum,
	output logic [31:0]        accept_total,
	output logic [31:0]        attempt_total,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tsm_pkg::*;

	tsm_cmd_t    cmd;
	tsm_status_t status;

	assign cfg_ready = 1'b1;

	tsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tsm_datapath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.site          (site),
		.spin_value    (spin_value),
		.log_draw      (log_draw),
		.accepted      (accepted),
		.site_spin     (site_spin),
		.energy_change (energy_change),
		.magnet_sum    (magnet_sum),
		.accept_total  (accept_total),
		.attempt_total (attempt_total)
	);

endmodule

>>> rtl/core/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer: lattice clear after reset, then one item at a time through
// lookup, neighbor reads, energy evaluation, write-back and result hand-off.
// ----------------------------------------------------------------------------
module tsm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tsm_pkg::tsm_status_t status,
	output tsm_pkg::tsm_cmd_t    cmd
);
	import tsm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SPLIT,
		S_WRAP,
		S_NB,
		S_SUM,
		S_MUL,
		S_LOC,
		S_JUDGE,
		S_LOAD,
		S_RESULT
	} state_t;

	localparam logic [2:0] NB_LAST = 3'(NB_COUNT - 1);

	state_t     state_q;
	logic [2:0] nb_cnt_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.take_in   = (state_q == S_IDLE) && in_valid;
		cmd.rd_site   = (state_q == S_LOOK);
		cmd.split     = (state_q == S_SPLIT);
		cmd.count_try = (state_q == S_SPLIT) && status.site_ok && (status.kind == KIND_TRY);
		cmd.wrap      = (state_q == S_WRAP);
		cmd.rd_nb     = (state_q == S_NB);
		cmd.nb_sel    = nb_cnt_q;
		cmd.mul       = (state_q == S_MUL);
		cmd.loc       = (state_q == S_LOC);
		cmd.judge     = (state_q == S_JUDGE);
		cmd.load_wr   = (state_q == S_LOAD);
		cmd.load_out  = (state_q == S_RESULT) && (!out_valid_q || out_ready);
		cmd.clr_step  = (state_q == S_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			nb_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (!status.site_ok) begin
						state_q <= S_RESULT;
					end else begin
						case (status.kind)
							KIND_LOAD: state_q <= S_LOAD;
							KIND_TRY:  state_q <= status.same ? S_RESULT : S_WRAP;
							KIND_READ: state_q <= S_RESULT;
							default:   state_q <= S_RESULT;
						endcase
					end
				end
				S_WRAP: begin
					nb_cnt_q <= '0;
					state_q  <= S_NB;
				end
				S_NB: begin
					nb_cnt_q <= nb_cnt_q + 3'd1;
					if (nb_cnt_q == NB_LAST) state_q <= S_SUM;
				end
				S_SUM:   state_q <= S_MUL;
				S_MUL:   state_q <= S_LOC;
				S_LOC:   state_q <= S_JUDGE;
				S_JUDGE: state_q <= S_RESULT;
				S_LOAD:  state_q <= S_RESULT;
				S_RESULT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.split |-> $past(cmd.rd_site))
		else $error("site lookup not issued before split");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("result valid without a result load");

endmodule

>>> rtl/core/tsm_datapath.sv
// ----------------------------------------------------------------------------
// tsm_datapath
// Lattice memory, site decode, neighbor addressing, energy arithmetic,
// acceptance test, magnetization and counters, result register.
// ----------------------------------------------------------------------------
module tsm_datapath #(
	parameter int COLS = 32,
	parameter int ROWS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsm_pkg::tsm_cmd_t      cmd,
	output tsm_pkg::tsm_status_t   status,
	input  logic                   cfg_valid,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             kind,
	input  logic [9:0]             site,
	input  logic signed [1:0]      spin_value,
	input  logic [15:0]            log_draw,
	output logic                   accepted,
	output logic signed [1:0]      site_spin,
	output logic signed [19:0]     energy_change,
	output logic signed [11:0]     magnet_sum,
	output logic [31:0]            accept_total,
	output logic [31:0]            attempt_total
);
	import tsm_pkg::*;

	localparam int CELL_COUNT = ROWS * COLS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int DIV_SH     = 20;
	localparam int PW         = DIV_SH + SITE_W;

	localparam logic [PW-1:0]     RECIP  = PW'((1 << DIV_SH) / COLS);
	localparam logic [SITE_W-1:0] COLS_V = SITE_W'(COLS);
	localparam logic [SITE_W-1:0] X_LAST = SITE_W'(COLS - 1);
	localparam logic [SITE_W-1:0] Y_LAST = SITE_W'(ROWS - 1);
	localparam logic [AW-1:0]     A_ONE  = AW'(1);
	localparam logic [AW-1:0]     A_CM1  = AW'(COLS - 1);
	localparam logic [AW-1:0]     A_COLS = AW'(COLS);
	localparam logic [AW-1:0]     A_WRAP = AW'((ROWS - 1) * COLS);
	localparam logic [AW-1:0]     A_LAST = AW'(CELL_COUNT - 1);

	// configuration
	logic        [15:0] temp_q;
	logic signed [15:0] coupling_q;
	logic signed [15:0] field_q;

	// item
	logic        [1:0]        kind_q;
	logic        [SITE_W-1:0] site_q;
	logic signed [1:0]        spin_q;
	logic        [15:0]       draw_q;

	// lattice
	logic [1:0]    mem [CELL_COUNT];
	logic [1:0]    rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [AW-1:0] clr_q;

	// decode and addressing
	logic [PW-1:0]       prod_q;
	logic [SITE_W-1:0]   row_est;
	logic [SITE_W-1:0]   row_cols;
	logic [SITE_W-1:0]   row_q;
	logic [SITE_W-1:0]   rem_q;
	logic [SITE_W-1:0]   x_v;
	logic [SITE_W-1:0]   y_v;
	logic                x_hi, x_lo, y_hi, y_lo;
	logic [AW-1:0]       site_a;
	logic [AW-1:0]       a_e, a_w, a_n, a_s, a_ne, a_sw;
	logic [AW-1:0]       nb_q [NB_COUNT];

	// arithmetic
	logic signed [1:0]  cur_dec;
	logic signed [1:0]  cur_q;
	logic signed [2:0]  d_q;
	logic               nb_pend_q;
	logic signed [3:0]  nsum_q;
	logic signed [19:0] cj_q;
	logic signed [19:0] local_v;
	logic signed [19:0] de_n;
	logic signed [19:0] de_q;
	logic        [31:0] tdraw_q;
	logic               take_v;
	logic               acc_q;
	logic signed [11:0] mag_q;
	logic        [31:0] acc_cnt_q;
	logic        [31:0] att_cnt_q;

	// result register
	logic               res_acc_q;
	logic signed [1:0]  res_spin_q;
	logic signed [19:0] res_de_q;
	logic signed [11:0] res_mag_q;
	logic        [31:0] res_acc_cnt_q;
	logic        [31:0] res_att_cnt_q;

	assign site_a  = AW'(site_q);
	assign cur_dec = spin_decode(rd_q);

	assign status.site_ok  = (32'(site_q) < 32'(CELL_COUNT));
	assign status.same     = (cur_dec == spin_q);
	assign status.kind     = kind_q;
	assign status.clr_last = (clr_q == A_LAST);

	// site / COLS by reciprocal; estimate is low by at most one
	assign row_est  = prod_q[PW-1:DIV_SH];
	assign row_cols = row_est * COLS_V;

	always_comb begin
		if (rem_q >= COLS_V) begin
			x_v = rem_q - COLS_V;
			y_v = row_q + SITE_W'(1);
		end else begin
			x_v = rem_q;
			y_v = row_q;
		end
		x_hi = (x_v == X_LAST);
		x_lo = (x_v == '0);
		y_hi = (y_v == Y_LAST);
		y_lo = (y_v == '0);
		a_e  = x_hi ? site_a - A_CM1 : site_a + A_ONE;
		a_w  = x_lo ? site_a + A_CM1 : site_a - A_ONE;
		a_n  = y_hi ? site_a - A_WRAP : site_a + A_COLS;
		a_s  = y_lo ? site_a + A_WRAP : site_a - A_COLS;
		a_ne = x_hi ? a_n - A_CM1 : a_n + A_ONE;
		a_sw = x_lo ? a_s + A_CM1 : a_s - A_ONE;
	end

	assign local_v = cj_q + 20'(field_q);

	always_comb begin
		case (d_q)
			3'b001:  de_n = -local_v;
			3'b111:  de_n = local_v;
			3'b010:  de_n = -(local_v <<< 1);
			3'b110:  de_n = local_v <<< 1;
			default: de_n = '0;
		endcase
	end

	assign take_v = (de_q <= 20'sd0) || ({de_q, 12'b0} < tdraw_q);

	assign rd_addr = cmd.rd_nb ? nb_q[cmd.nb_sel] : site_a;
	assign wr_addr = cmd.clr_step ? clr_q : site_a;
	assign wr_en   = cmd.clr_step || cmd.load_wr || (cmd.judge && take_v);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.clr_step ? 2'b00 : spin_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q  <= PW'(site_q) * RECIP;
		tdraw_q <= 32'(temp_q) * 32'(draw_q);
		if (cmd.take_in) begin
			kind_q <= kind;
			site_q <= site;
			spin_q <= spin_decode(spin_value);
			draw_q <= log_draw;
		end
		if (cmd.split) begin
			row_q <= row_est;
			rem_q <= site_q - row_cols;
			d_q   <= 3'(spin_q) - 3'(cur_dec);
		end
		if (cmd.wrap) begin
			nb_q[0] <= a_e;
			nb_q[1] <= a_w;
			nb_q[2] <= a_n;
			nb_q[3] <= a_s;
			nb_q[4] <= a_ne;
			nb_q[5] <= a_sw;
		end
		if (cmd.mul) begin
			cj_q <= 20'(coupling_q) * 20'(nsum_q);
		end
		if (cmd.load_out) begin
			res_acc_q     <= acc_q;
			res_spin_q    <= cur_q;
			res_de_q      <= de_q;
			res_mag_q     <= mag_q;
			res_acc_cnt_q <= acc_cnt_q;
			res_att_cnt_q <= att_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q     <= TEMPERATURE_RESET;
			coupling_q <= COUPLING_RESET;
			field_q    <= FIELD_RESET;
			clr_q      <= '0;
			nb_pend_q  <= 1'b0;
			nsum_q     <= '0;
			cur_q      <= '0;
			de_q       <= '0;
			acc_q      <= 1'b0;
			mag_q      <= '0;
			acc_cnt_q  <= '0;
			att_cnt_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TEMPERATURE: temp_q     <= cfg_data;
					CFG_COUPLING:    coupling_q <= $signed(cfg_data);
					CFG_FIELD:       field_q    <= $signed(cfg_data);
					default:         ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + A_ONE;
			nb_pend_q <= cmd.rd_nb;
			if (cmd.split) begin
				nsum_q <= '0;
			end else if (nb_pend_q) begin
				nsum_q <= nsum_q + 4'(cur_dec);
			end
			if (cmd.take_in) begin
				de_q  <= '0;
				acc_q <= 1'b0;
			end
			if (cmd.split) begin
				cur_q <= status.site_ok ? cur_dec : 2'sb00;
			end
			if (cmd.count_try && (att_cnt_q != '1)) begin
				att_cnt_q <= att_cnt_q + 32'd1;
			end
			if (cmd.loc) de_q <= de_n;
			if (cmd.load_wr) begin
				cur_q <= spin_q;
				mag_q <= mag_q + 12'(d_q);
			end
			if (cmd.judge && take_v) begin
				cur_q <= spin_q;
				acc_q <= 1'b1;
				mag_q <= mag_q + 12'(d_q);
				if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + 32'd1;
			end
		end
	end

	assign accepted      = res_acc_q;
	assign site_spin     = res_spin_q;
	assign energy_change = res_de_q;
	assign magnet_sum    = res_mag_q;
	assign accept_total  = res_acc_cnt_q;
	assign attempt_total = res_att_cnt_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(nsum_q >= -4'sd6) && (nsum_q <= 4'sd6))
		else $error("neighbor sum out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= att_cnt_q)
		else $error("accept count above attempt count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(de_q >= -20'sd458752) && (de_q <= 20'sd458752))
		else $error("energy change out of range");

endmodule

>>> dv/tb_ternary_spin_metropolis_update_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ternary_spin_metropolis_update_top
// Drives load, attempt and read words into the spin lattice block and checks
// every result word against a local lattice model. The model tracks spins,
// magnetization and the attempt and accept counts. Runs cover the reset
// settings, zero and full temperature, extreme couplings and fields, and
// random settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_ternary_spin_metropolis_update_top;
	import tsm_pkg::*;

	localparam int LAT_COLS   = 32;
	localparam int LAT_ROWS   = 32;
	localparam int CELLS      = LAT_ROWS * LAT_COLS;
	localparam int SETTLE     = 24;
	localparam int CYCLE_CAP  = 1000000;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] SPIN_ZERO  = 2'b00;
	localparam logic [1:0] SPIN_UP    = 2'b01;
	localparam logic [1:0] SPIN_ALIAS = 2'b10;
	localparam logic [1:0] SPIN_DOWN  = 2'b11;

	typedef struct packed {
		logic               accepted;
		logic signed [1:0]  site_spin;
		logic signed [19:0] energy_change;
		logic signed [11:0] magnet_sum;
		logic [31:0]        accept_total;
		logic [31:0]        attempt_total;
	} spin_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         kind = '0;
	logic [9:0]         site = '0;
	logic signed [1:0]  spin_value = '0;
	logic [15:0]        log_draw = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic signed [1:0]  site_spin;
	logic signed [19:0] energy_change;
	logic signed [11:0] magnet_sum;
	logic [31:0]        accept_total;
	logic [31:0]        attempt_total;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	ternary_spin_metropolis_update_top #(
		.COLS(LAT_COLS),
		.ROWS(LAT_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.site(site),
		.spin_value(spin_value),
		.log_draw(log_draw),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.site_spin(site_spin),
		.energy_change(energy_change),
		.magnet_sum(magnet_sum),
		.accept_total(accept_total),
		.attempt_total(attempt_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// lattice model state
	int          lattice [CELLS];
	int          magnet;
	int unsigned accept_count;
	int unsigned attempt_count;
	int unsigned temp_q;
	int          coupling_q;
	int          field_q;

	spin_report_t spin_reports [$];
	int           mismatches = 0;
	bit           quiet = 1'b0;
	int           sink_hold = 0;

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int spin_of(logic [1:0] code);
		case (code)
			SPIN_UP:   return 1;
			SPIN_DOWN: return -1;
			default:   return 0;
		endcase
	endfunction

	function automatic int neighbor_total(int idx);
		int y, x, xe, xw, yn, ys;
		y  = idx / LAT_COLS;
		x  = idx % LAT_COLS;
		xe = (x + 1) % LAT_COLS;
		xw = (x + LAT_COLS - 1) % LAT_COLS;
		yn = (y + 1) % LAT_ROWS;
		ys = (y + LAT_ROWS - 1) % LAT_ROWS;
		return lattice[y * LAT_COLS + xe] + lattice[y * LAT_COLS + xw]
			+ lattice[yn * LAT_COLS + x] + lattice[ys * LAT_COLS + x]
			+ lattice[yn * LAT_COLS + xe] + lattice[ys * LAT_COLS + xw];
	endfunction

	function automatic spin_report_t metropolis_step(logic [1:0] k, logic [9:0] s,
			logic [1:0] code, logic [15:0] draw);
		spin_report_t r;
		int           idx, cur, prop, d, field_sum, de;
		logic         take;
		r = '0;
		idx = int'(s);
		prop = spin_of(code);
		cur = 0;
		de = 0;
		if (idx < CELLS) begin
			cur = lattice[idx];
			case (k)
				KIND_LOAD: begin
					magnet += prop - cur;
					lattice[idx] = prop;
					cur = prop;
				end
				KIND_TRY: begin
					if (attempt_count != 32'hFFFF_FFFF)
						attempt_count++;
					if (prop != cur) begin
						d = prop - cur;
						field_sum = coupling_q * neighbor_total(idx) + field_q;
						de = -d * field_sum;
						take = (de <= 0) ||
							((longint'(de) << 12) < longint'(temp_q) * longint'(draw));
						if (take) begin
							magnet += d;
							lattice[idx] = prop;
							cur = prop;
							r.accepted = 1'b1;
							if (accept_count != 32'hFFFF_FFFF)
								accept_count++;
						end
					end
				end
				default: ;
			endcase
		end
		r.site_spin     = cur[1:0];
		r.energy_change = de[19:0];
		r.magnet_sum    = magnet[11:0];
		r.accept_total  = accept_count;
		r.attempt_total = attempt_count;
		return r;
	endfunction

	task automatic report_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		spin_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (spin_reports.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none outstanding", $time);
			end else begin
				want = spin_reports.pop_front();
				report_field("accepted", longint'(want.accepted), longint'(accepted));
				report_field("site_spin", longint'(want.site_spin), longint'(site_spin));
				report_field("energy_change", longint'(want.energy_change),
					longint'(energy_change));
				report_field("magnet_sum", longint'(want.magnet_sum),
					longint'(magnet_sum));
				report_field("accept_total", longint'(want.accept_total),
					longint'(accept_total));
				report_field("attempt_total", longint'(want.attempt_total),
					longint'(attempt_total));
			end
		end
	end

	always @(negedge clk) begin
		int n;
		if (quiet) begin
			out_ready <= 1'b1;
			sink_hold <= 0;
		end else if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			n = ($urandom_range(0, 99) < 25) ? pause_len() : 0;
			out_ready <= (n == 0);
			sink_hold <= (n > 0) ? n - 1 : 0;
		end
	end

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_word(input logic [1:0] k, input logic [9:0] s,
			input logic [1:0] code, input logic [15:0] draw);
		int gap;
		gap = quiet ? 0 : pause_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		kind       <= k;
		site       <= s;
		spin_value <= code;
		log_draw   <= draw;
		do @(posedge clk); while (!in_ready);
		spin_reports.push_back(metropolis_step(k, s, code, draw));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (spin_reports.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TEMPERATURE: temp_q = 32'(data);
			CFG_COUPLING:    coupling_q = int'($signed(data));
			CFG_FIELD:       field_q = int'($signed(data));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_lattice_params(input logic [15:0] t, input logic [15:0] j,
			input logic [15:0] h);
		settle();
		write_reg(CFG_TEMPERATURE, t);
		write_reg(CFG_COUPLING, j);
		write_reg(CFG_FIELD, h);
	endtask

	function automatic logic [1:0] random_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return SPIN_ALIAS;
		else if (r < 40)
			return SPIN_UP;
		else if (r < 72)
			return SPIN_DOWN;
		return SPIN_ZERO;
	endfunction

	function automatic logic [15:0] random_draw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h0000;
		else if (r < 20)
			return 16'hFFFF;
		else if (r < 60)
			return 16'($urandom_range(0, 8191));
		return 16'($urandom_range(0, 65535));
	endfunction

	// fill a 4x8 patch around a random corner, then hammer it with mixed words
	task automatic run_phase(input int n);
		int          base_r, base_c, r, i;
		logic [9:0]  s;
		logic [1:0]  k;
		base_r = $urandom_range(0, LAT_ROWS - 1);
		base_c = $urandom_range(0, LAT_COLS - 1);
		for (i = 0; i < 32; i++)
			send_word(KIND_LOAD, 10'(((base_r + i / 8) % LAT_ROWS) * LAT_COLS
				+ (base_c + i % 8) % LAT_COLS), random_code(), random_draw());
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				k = KIND_LOAD;
			else if (r < 85)
				k = KIND_TRY;
			else if (r < 95)
				k = KIND_READ;
			else
				k = KIND_SPARE;
			if ($urandom_range(0, 99) < 80)
				s = 10'(((base_r + $urandom_range(0, 3)) % LAT_ROWS) * LAT_COLS
					+ (base_c + $urandom_range(0, 7)) % LAT_COLS);
			else
				s = 10'($urandom_range(0, CELLS - 1));
			send_word(k, s, random_code(), random_draw());
			if ($urandom_range(0, 199) < 3)
				drain_results();
		end
	endtask

	task automatic test_lattice_basics();
		send_word(KIND_READ, 10'd0, SPIN_UP, 16'h0000);
		send_word(KIND_LOAD, 10'd0, SPIN_UP, 16'hFFFF);
		send_word(KIND_LOAD, 10'd1023, SPIN_DOWN, 16'h0000);
		send_word(KIND_LOAD, 10'd1, SPIN_UP, 16'h0000);
		send_word(KIND_LOAD, 10'd32, SPIN_UP, 16'h0000);
		send_word(KIND_LOAD, 10'd33, SPIN_DOWN, 16'h0000);
		send_word(KIND_LOAD, 10'd31, SPIN_ALIAS, 16'h0000);
		send_word(KIND_LOAD, 10'd992, SPIN_DOWN, 16'h0000);
		send_word(KIND_TRY, 10'd0, SPIN_UP, 16'hFFFF);
		send_word(KIND_TRY, 10'd0, SPIN_DOWN, 16'h0000);
		send_word(KIND_TRY, 10'd0, SPIN_DOWN, 16'hFFFF);
		send_word(KIND_TRY, 10'd992, SPIN_ZERO, 16'h0001);
		send_word(KIND_SPARE, 10'd0, SPIN_DOWN, 16'hFFFF);
		send_word(KIND_LOAD, 10'd1, SPIN_ALIAS, 16'h0000);
		send_word(KIND_TRY, 10'd1023, SPIN_ALIAS, 16'h8000);
		send_word(KIND_TRY, 10'd1023, SPIN_UP, 16'h0001);
		send_word(KIND_TRY, 10'd31, SPIN_UP, 16'h7FFF);
		send_word(KIND_READ, 10'd1023, SPIN_ZERO, 16'hFFFF);
		send_word(KIND_READ, 10'd512, SPIN_ALIAS, 16'h5555);
		send_word(KIND_READ, 10'd0, SPIN_UP, 16'hAAAA);
	endtask

	task automatic test_zero_temperature();
		set_lattice_params(16'd0, 16'd256, 16'h0080);
		run_phase(120);
	endtask

	task automatic test_strong_coupling();
		set_lattice_params(16'hFFFF, 16'h7FFF, 16'h8000);
		run_phase(120);
	endtask

	task automatic test_antiferro_field();
		set_lattice_params(16'd1, 16'h8000, 16'h7FFF);
		run_phase(120);
	endtask

	task automatic test_random_settings();
		logic [15:0] t, j, h;
		int          p;
		for (p = 0; p < 5; p++) begin
			t = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1024))
				: 16'($urandom_range(0, 65535));
			j = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 1536) - 768)
				: 16'($urandom_range(0, 65535));
			h = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 2048) - 1024)
				: 16'($urandom_range(0, 65535));
			set_lattice_params(t, j, h);
			run_phase(210);
		end
	endtask

	task automatic test_back_to_back();
		settle();
		quiet = 1'b1;
		run_phase(150);
		drain_results();
		quiet = 1'b0;
	endtask

	initial begin
		foreach (lattice[i])
			lattice[i] = 0;
		magnet        = 0;
		accept_count  = 0;
		attempt_count = 0;
		temp_q        = 32'(TEMPERATURE_RESET);
		coupling_q    = int'(COUPLING_RESET);
		field_q       = int'(FIELD_RESET);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_lattice_basics();
		test_zero_temperature();
		test_strong_coupling();
		test_antiferro_field();
		test_random_settings();
		test_back_to_back();

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
